/* rtl/crv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package crv_pkg;

    // Header layout and CRC-32 constants.
    localparam int          HDR_LEN  = 8;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam logic CFG_VERSION     = 1'b0;
    localparam logic CFG_PAYLOAD_LEN = 1'b1;

    // One input item: a blob byte and its end marker.
    typedef struct packed {
        logic [7:0] blob_byte;
        logic       last_byte;
    } t_crv_in;

    // Result status codes, in check priority order.
    typedef enum logic [2:0] {
        CRV_OK         = 3'd0,
        CRV_TOO_LONG   = 3'd1,
        CRV_TOO_SHORT  = 3'd2,
        CRV_VERSION    = 3'd3,
        CRV_HDR_LENGTH = 3'd4,
        CRV_EXP_LENGTH = 3'd5,
        CRV_CRC        = 3'd6
    } t_crv_status;

    // One result item.
    typedef struct packed {
        t_crv_status status;
        logic [8:0]  blob_length;
    } t_crv_result;

    // Where a byte goes once it has been classified.
    typedef enum logic [1:0] {
        KIND_HDR,
        KIND_PAY,
        KIND_SKIP
    } t_crv_kind;

    // Classified byte handed from the front end to the back end.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        t_crv_kind   kind;
        logic [2:0]  hdr_idx;
        logic        too_long;
        logic        too_short;
        logic [15:0] pay_len;
        logic [8:0]  blob_length;
    } t_crv_op;

    // Configuration register values.
    typedef struct packed {
        logic [15:0] req_version;
        logic [8:0]  expected_payload_length;
    } t_crv_cfg;

    // One byte of a reflected CRC-32 update, unrolled over eight bits.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/crv_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module crv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             w_push;
    logic             w_pop;

    // Status flags; writes only land when there is room.
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and occupancy updates with wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/crv_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module crv_front #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire crv_pkg::t_crv_in i_item,
    output crv_pkg::t_crv_op      o_op
);

    localparam int MAX_BLOB = MAX_PAYLOAD + crv_pkg::HDR_LEN;
    localparam int CW       = $clog2(MAX_BLOB + 2);
    localparam int PW       = (CW > 16) ? CW : 16;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] w_len;
    logic [PW-1:0] w_pay_diff;

    // Byte count after this byte, saturating one past the largest blob.
    assign w_len      = (r_count <= CW'(MAX_BLOB)) ? r_count + CW'(1) : r_count;
    assign w_pay_diff = PW'(w_len) - PW'(crv_pkg::HDR_LEN);

    // Classify the byte by its position and precompute the length checks.
    always_comb begin
        o_op.data        = i_item.blob_byte;
        o_op.last        = i_item.last_byte;
        o_op.hdr_idx     = r_count[2:0];
        o_op.too_long    = (w_len > CW'(MAX_BLOB));
        o_op.too_short   = (w_len < CW'(crv_pkg::HDR_LEN));
        o_op.pay_len     = w_pay_diff[15:0];
        o_op.blob_length = 9'(w_len);
        if (r_count < CW'(crv_pkg::HDR_LEN)) begin
            o_op.kind = crv_pkg::KIND_HDR;
        end else if (r_count < CW'(MAX_BLOB)) begin
            o_op.kind = crv_pkg::KIND_PAY;
        end else begin
            o_op.kind = crv_pkg::KIND_SKIP;
        end
    end

    // The count re-arms after the last byte of a blob.
    always_comb begin
        n_count = r_count;
        if (i_accept) begin
            n_count = i_item.last_byte ? '0 : w_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/crv_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module crv_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire crv_pkg::t_crv_op  i_op,
    input  wire logic              i_op_empty,
    output logic                   o_op_pop,
    input  wire crv_pkg::t_crv_cfg i_cfg,
    input  wire logic              i_res_full,
    output logic                   o_res_push,
    output crv_pkg::t_crv_result   o_res
);

    logic [63:0] r_hdr;
    logic [63:0] n_hdr;
    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] w_crc_step;
    logic [15:0] w_ver;
    logic [15:0] w_hlen;
    logic [31:0] w_hcrc;

    // A byte is consumed unless it closes a blob and the result queue is full.
    assign o_op_pop   = !i_op_empty && (!i_op.last || !i_res_full);
    assign o_res_push = o_op_pop && i_op.last;
    assign w_crc_step = crv_pkg::crc_byte(r_crc, i_op.data);

    // Header capture and CRC update for the byte being consumed.
    always_comb begin
        n_hdr = r_hdr;
        n_crc = r_crc;
        unique case (i_op.kind)
            crv_pkg::KIND_HDR: n_hdr[{i_op.hdr_idx, 3'b000} +: 8] = i_op.data;
            crv_pkg::KIND_PAY: n_crc = w_crc_step;
            default: ;
        endcase
    end

    assign w_ver  = n_hdr[15:0];
    assign w_hlen = n_hdr[31:16];
    assign w_hcrc = n_hdr[63:32];

    // Final status in check priority order.
    always_comb begin
        o_res.blob_length = i_op.blob_length;
        priority if (i_op.too_long) begin
            o_res.status = crv_pkg::CRV_TOO_LONG;
        end else if (i_op.too_short) begin
            o_res.status = crv_pkg::CRV_TOO_SHORT;
        end else if (w_ver != i_cfg.req_version) begin
            o_res.status = crv_pkg::CRV_VERSION;
        end else if (w_hlen != i_op.pay_len) begin
            o_res.status = crv_pkg::CRV_HDR_LENGTH;
        end else if (w_hlen != {7'd0, i_cfg.expected_payload_length}) begin
            o_res.status = crv_pkg::CRV_EXP_LENGTH;
        end else if (~n_crc != w_hcrc) begin
            o_res.status = crv_pkg::CRV_CRC;
        end else begin
            o_res.status = crv_pkg::CRV_OK;
        end
    end

    // The CRC restarts after each blob; every header byte is rewritten before use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= crv_pkg::CRC_INIT;
        end else if (o_op_pop) begin
            r_crc <= i_op.last ? crv_pkg::CRC_INIT : n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_hdr <= n_hdr;
        end
    end

endmodule

`default_nettype wire

/* rtl/crc32_record_validator_core.sv */
// Record blob checker: header fields plus CRC-32 over the payload.
// Input channel: present one blob byte per item on i_item with last_byte set
// on the final byte; the item is taken at an edge with push high and full low.
// Blobs follow each other with no gap; every blob gives exactly one result.
// Result channel: while empty is low, o_result holds the oldest result
// (status and saturated blob length); it is taken at an edge with pop high.
// Configuration: i_cfg_index selects the required header version (0) or the
// required payload length (1); o_cfg_ready is always high.
// Throughput is one byte per cycle while the result queue has room, set by the
// byte-wide CRC update in the back end. A result passes through the queue between
// front and back end and then the result queue before it shows on o_result.
// When pop stays low, two results are held; the back end then waits on a
// last byte, the two-entry queue between front and back end fills, and full
// rises.
// Reset (synchronous, active low) empties both queues, clears the byte count,
// restarts the CRC and sets both configuration registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module crc32_record_validator_core #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    input  wire crv_pkg::t_crv_in     i_item,
    output logic                      full,
    input  wire logic                 pop,
    output crv_pkg::t_crv_result      o_result,
    output logic                      empty,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    localparam int OP_W  = $bits(crv_pkg::t_crv_op);
    localparam int RES_W = $bits(crv_pkg::t_crv_result);

    crv_pkg::t_crv_cfg    r_cfg;
    crv_pkg::t_crv_op     w_front_op;
    crv_pkg::t_crv_op     w_back_op;
    crv_pkg::t_crv_result w_res;
    logic [OP_W-1:0]      w_mid_data;
    logic [RES_W-1:0]     w_out_data;
    logic                 w_accept;
    logic                 w_mid_empty;
    logic                 w_mid_pop;
    logic                 w_res_push;
    logic                 w_res_full;

    assign w_accept    = push && !full;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                crv_pkg::CFG_VERSION:     r_cfg.req_version <= i_cfg_data;
                crv_pkg::CFG_PAYLOAD_LEN: r_cfg.expected_payload_length <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Front end: position tracking and classification.
    crv_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_item  (i_item),
        .o_op    (w_front_op)
    );

    // Queue between front and back end.
    crv_fifo #(
        .WIDTH(OP_W),
        .DEPTH(2)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_accept),
        .i_data (w_front_op),
        .o_full (full),
        .i_pop  (w_mid_pop),
        .o_data (w_mid_data),
        .o_empty(w_mid_empty)
    );

    assign w_back_op = w_mid_data;

    // Back end: header capture, CRC and status.
    crv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_back_op),
        .i_op_empty(w_mid_empty),
        .o_op_pop  (w_mid_pop),
        .i_cfg     (r_cfg),
        .i_res_full(w_res_full),
        .o_res_push(w_res_push),
        .o_res     (w_res)
    );

    // Result queue toward the receiver.
    crv_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (w_out_data),
        .o_empty(empty)
    );

    assign o_result = w_out_data;

    // A result is only produced when the result queue has room.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result produced while result queue full");

    // An accepted byte is visible to the back end on the next cycle.
    a_mid_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !w_mid_empty)
        else $error("accepted byte missing from front-to-back queue");

    // The back end never consumes from an empty queue.
    a_mid_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> !w_mid_empty)
        else $error("back end consumed from an empty queue");

endmodule

`default_nettype wire
